// File: design/tsf_pkg.sv
// Shared types and constants for the triangle span fill block.
// Holds the request structs, the controller/datapath command and status
// structs and the edge codes. Depends on nothing.
`default_nettype none

package tsf_pkg;

    // Coordinate widths, fixed by the request fields
    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int CLR_W  = 8;

    // Column accumulator: signed, with headroom for steps of either sign
    localparam int ACC_W  = COL_W + 2;
    // Remainder accumulator: holds a sum of two remainders below the height
    localparam int REM_W  = ROW_W + 1;
    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = COL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Edge codes
    localparam logic [1:0] EDGE_LONG = 2'd0;  // v0 -> v2
    localparam logic [1:0] EDGE_01   = 2'd1;  // v0 -> v1
    localparam logic [1:0] EDGE_12   = 2'd2;  // v1 -> v2
    localparam int NUM_EDGES = 3;

    typedef struct packed {
        logic [COL_W-1:0] ax_col;
        logic [ROW_W-1:0] ay_row;
        logic [COL_W-1:0] bx_col;
        logic [ROW_W-1:0] by_row;
        logic [COL_W-1:0] cx_col;
        logic [ROW_W-1:0] cy_row;
        logic [CLR_W-1:0] fill_color;
    } tsf_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] span_row;
        logic [COL_W-1:0] left_col;
        logic [COL_W-1:0] right_col;
        logic [CLR_W-1:0] span_color;
        logic             is_empty;
        logic             is_last;
    } tsf_out_t;

    typedef struct packed {
        logic       load;        // take in and sort a new triangle
        logic       div_start;   // start a division for start_sel
        logic       div_latch;   // store the finished division for edge_sel
        logic       emit_span;   // write one span and advance a row
        logic       emit_empty;  // write the empty result
        logic [1:0] start_sel;
        logic [1:0] edge_sel;
    } tsf_cmd_t;

    typedef struct packed {
        logic flat;      // zero height
        logic div_done;  // divider finished this cycle
        logic out_free;  // output register can take a request
        logic last_row;  // current row is the bottom row
    } tsf_stat_t;

endpackage

`default_nettype wire

// File: design/tsf_div.sv
// Shift-and-subtract unsigned divider, one quotient bit per cycle.
// Used by the datapath for the per-edge step quotients. Depends on tsf_pkg.
`default_nettype none

module tsf_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [tsf_pkg::COL_W-1:0] num,
    input  wire logic [tsf_pkg::ROW_W-1:0] den,
    output logic                          done,
    output logic [tsf_pkg::COL_W-1:0]     quo,
    output logic [tsf_pkg::ROW_W-1:0]     rem
);
    import tsf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]     quo_reg, quo_next;
    logic [ROW_W-1:0]     den_reg, den_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[ROW_W-1:0], quo_reg[COL_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            quo_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // bring down the next numerator bit, subtract if it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[COL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[COL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[ROW_W-1:0];

endmodule

`default_nettype wire

// File: design/tsf_dpath.sv
// Datapath: vertex sort, per-edge step setup through the shared divider,
// incremental edge walkers and the output register.
// Depends on tsf_pkg and tsf_div.
`default_nettype none

module tsf_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tsf_pkg::tsf_in_t  triangle,
    input  wire tsf_pkg::tsf_cmd_t cmd,
    input  wire logic              span_stall,
    output tsf_pkg::tsf_stat_t     stat,
    output logic                   span_valid,
    output tsf_pkg::tsf_out_t      span
);
    import tsf_pkg::*;

    // sorted vertices
    logic [COL_W-1:0] x_reg [NUM_EDGES];
    logic [ROW_W-1:0] y_reg [NUM_EDGES];
    logic [CLR_W-1:0] color_reg;
    logic [ROW_W-1:0] row_reg;

    // edge walkers: column, remainder, and per-row step
    logic signed [ACC_W-1:0] acc_c_reg  [NUM_EDGES];
    logic        [ROW_W-1:0] acc_r_reg  [NUM_EDGES];
    logic signed [ACC_W-1:0] step_q_reg [NUM_EDGES];
    logic        [ROW_W-1:0] step_r_reg [NUM_EDGES];
    logic                    neg_reg;

    logic                    span_valid_reg;
    tsf_out_t                span_reg, span_next;

    // sort network
    logic [COL_W-1:0] sx0, sx1, sx2, tx;
    logic [ROW_W-1:0] sy0, sy1, sy2, ty;

    logic        [ROW_W-1:0] den [NUM_EDGES];
    logic signed [ACC_W-1:0] dx  [NUM_EDGES];

    logic signed [ACC_W-1:0] start_dx;
    logic signed [ACC_W-1:0] start_abs;
    logic        [ROW_W-1:0] start_den;
    logic        [ROW_W-1:0] lat_den;

    logic                    div_done;
    logic [COL_W-1:0]        div_quo;
    logic [ROW_W-1:0]        div_rem;

    logic signed [ACC_W-1:0] adj_q;
    logic        [ROW_W-1:0] adj_r;

    logic                    second;
    logic signed [ACC_W-1:0] ea, eb, lo, hi;
    logic                    out_free;

    always_comb
    begin
        tx  = '0;
        ty  = '0;
        sx0 = triangle.ax_col; sy0 = triangle.ay_row;
        sx1 = triangle.bx_col; sy1 = triangle.by_row;
        sx2 = triangle.cx_col; sy2 = triangle.cy_row;
        if (sy0 > sy1)
        begin
            ty = sy0; sy0 = sy1; sy1 = ty;
            tx = sx0; sx0 = sx1; sx1 = tx;
        end
        if (sy1 > sy2)
        begin
            ty = sy1; sy1 = sy2; sy2 = ty;
            tx = sx1; sx1 = sx2; sx2 = tx;
        end
        if (sy0 > sy1)
        begin
            ty = sy0; sy0 = sy1; sy1 = ty;
            tx = sx0; sx0 = sx1; sx1 = tx;
        end
    end

    // edge heights and column deltas
    always_comb
    begin
        den[EDGE_LONG] = y_reg[2] - y_reg[0];
        den[EDGE_01]   = y_reg[1] - y_reg[0];
        den[EDGE_12]   = y_reg[2] - y_reg[1];
        dx[EDGE_LONG]  = $signed({2'b00, x_reg[2]}) - $signed({2'b00, x_reg[0]});
        dx[EDGE_01]    = $signed({2'b00, x_reg[1]}) - $signed({2'b00, x_reg[0]});
        dx[EDGE_12]    = $signed({2'b00, x_reg[2]}) - $signed({2'b00, x_reg[1]});
    end

    always_comb
    begin
        case (cmd.start_sel)
            EDGE_01:
            begin
                start_dx  = dx[EDGE_01];
                start_den = den[EDGE_01];
            end
            EDGE_12:
            begin
                start_dx  = dx[EDGE_12];
                start_den = den[EDGE_12];
            end
            default:
            begin
                start_dx  = dx[EDGE_LONG];
                start_den = den[EDGE_LONG];
            end
        endcase
        start_abs = start_dx[ACC_W-1] ? -start_dx : start_dx;
        case (cmd.edge_sel)
            EDGE_01: lat_den = den[EDGE_01];
            EDGE_12: lat_den = den[EDGE_12];
            default: lat_den = den[EDGE_LONG];
        endcase
    end

    tsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (start_abs[COL_W-1:0]),
        .den   (start_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // turn the truncated magnitude quotient into a floor quotient
    always_comb
    begin
        adj_q = $signed({2'b00, div_quo});
        adj_r = div_rem;
        if (neg_reg)
        begin
            adj_q = -$signed({2'b00, div_quo});
            if (div_rem != '0)
            begin
                adj_q = adj_q - ACC_W'(1);
                adj_r = lat_den - div_rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            neg_reg <= start_dx[ACC_W-1];
    end

    // span ends
    always_comb
    begin
        second = (row_reg > y_reg[1]) || (y_reg[1] == y_reg[0]);
        ea     = acc_c_reg[EDGE_LONG];
        eb     = second ? acc_c_reg[EDGE_12] : acc_c_reg[EDGE_01];
        lo     = (ea < eb) ? ea : eb;
        hi     = (ea < eb) ? eb : ea;
    end

    assign out_free = !span_valid_reg || !span_stall;

    always_comb
    begin
        span_next = span_reg;
        if (cmd.emit_empty)
        begin
            span_next.span_row   = '0;
            span_next.left_col   = '0;
            span_next.right_col  = '0;
            span_next.span_color = color_reg;
            span_next.is_empty   = 1'b1;
            span_next.is_last    = 1'b1;
        end
        else if (cmd.emit_span)
        begin
            span_next.span_row   = row_reg;
            span_next.left_col   = lo[COL_W-1:0];
            span_next.right_col  = hi[COL_W-1:0];
            span_next.span_color = color_reg;
            span_next.is_empty   = 1'b0;
            span_next.is_last    = (row_reg == y_reg[2]);
        end
    end

    // load, step setup and row advance
    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        if (cmd.load)
        begin
            x_reg[0]  <= sx0; x_reg[1] <= sx1; x_reg[2] <= sx2;
            y_reg[0]  <= sy0; y_reg[1] <= sy1; y_reg[2] <= sy2;
            color_reg <= triangle.fill_color;
            row_reg   <= sy0;
            acc_c_reg[EDGE_LONG] <= $signed({2'b00, sx0});
            acc_c_reg[EDGE_01]   <= $signed({2'b00, sx0});
            acc_c_reg[EDGE_12]   <= $signed({2'b00, sx1});
            for (int e = 0; e < NUM_EDGES; e++)
                acc_r_reg[e] <= '0;
        end
        if (cmd.div_latch)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (cmd.edge_sel == 2'(e))
                begin
                    step_q_reg[e] <= adj_q;
                    step_r_reg[e] <= adj_r;
                end
            end
        end
        if (cmd.emit_span)
        begin
            row_reg <= row_reg + 1'b1;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                // the second short edge only starts moving from the middle row
                if (2'(e) != EDGE_12 || row_reg >= y_reg[1])
                begin
                    if (({1'b0, acc_r_reg[e]} + {1'b0, step_r_reg[e]})
                        >= {1'b0, den[e]})
                    begin
                        acc_c_reg[e] <= acc_c_reg[e] + step_q_reg[e] + ACC_W'(1);
                        acc_r_reg[e] <= ROW_W'({1'b0, acc_r_reg[e]}
                                        + {1'b0, step_r_reg[e]} - {1'b0, den[e]});
                    end
                    else
                    begin
                        acc_c_reg[e] <= acc_c_reg[e] + step_q_reg[e];
                        acc_r_reg[e] <= acc_r_reg[e] + step_r_reg[e];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_valid_reg <= 1'b0;
        else if (cmd.emit_span || cmd.emit_empty)
            span_valid_reg <= 1'b1;
        else if (!span_stall)
            span_valid_reg <= 1'b0;
    end

    assign stat.flat     = (y_reg[0] == y_reg[2]);
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign stat.last_row = (row_reg == y_reg[2]);

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

endmodule

`default_nettype wire

// File: design/tsf_ctrl.sv
// Controller state machine: accepts a triangle, sequences the edge
// divisions, then issues one span per free output slot; a flat triangle
// skips the divisions and gets the empty result. Depends on tsf_pkg.
`default_nettype none

module tsf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               triangle_valid,
    input  wire tsf_pkg::tsf_stat_t stat,
    output logic                    triangle_stall,
    output tsf_pkg::tsf_cmd_t       cmd
);
    import tsf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SPAN  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] edge_reg, edge_next;

    always_comb
    begin
        state_next    = state_reg;
        edge_next     = edge_reg;
        cmd           = '0;
        cmd.edge_sel  = edge_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (triangle_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (stat.flat)
                    state_next = ST_EMPTY;
                else
                begin
                    edge_next     = EDGE_LONG;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    if (edge_reg == EDGE_12)
                        state_next = ST_SPAN;
                    else
                    begin
                        edge_next     = edge_reg + 1'b1;
                        cmd.div_start = 1'b1;
                    end
                end
            end
            ST_SPAN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_span = 1'b1;
                    if (stat.last_row)
                        state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.start_sel = edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= EDGE_LONG;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
        end
    end

    assign triangle_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// File: design/triangle_span_fill_colored.sv
// Scanline triangle fill. A triangle request carries three vertices and a
// colour; the block sorts the vertices by row and returns one span request
// per row from the top vertex row to the bottom one, each with its row, the
// inclusive left and right columns and the colour, the final one marked
// is_last. A triangle of zero height returns a single request marked empty
// and last. End columns follow the long edge and the active short edge with
// exact floor stepping, vertex column plus floor(delta * rows / height).
// Flow: one triangle at a time. After the accept cycle the set-up state
// checks for a flat triangle, then the edge steps come one after
// another from a shared one-bit-per-cycle divider; then one span per cycle
// while the output is not stalled, height + 1 spans. A flat triangle goes
// from set-up straight to the empty result. The output register lets the
// next triangle be taken while the final span still waits downstream.
// Depends on tsf_pkg, tsf_ctrl, tsf_dpath and tsf_div.
`default_nettype none

module triangle_span_fill_colored (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             triangle_valid,
    output logic                  triangle_stall,
    input  wire tsf_pkg::tsf_in_t triangle,
    output logic                  span_valid,
    input  wire logic             span_stall,
    output tsf_pkg::tsf_out_t     span
);
    import tsf_pkg::*;

    tsf_cmd_t  cmd;
    tsf_stat_t stat;

    // Sequence set-up and span issue
    tsf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .triangle_valid (triangle_valid),
        .stat           (stat),
        .triangle_stall (triangle_stall),
        .cmd            (cmd)
    );

    // Hold the sorted vertices, walk the edges, drive the output register
    tsf_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .triangle   (triangle),
        .cmd        (cmd),
        .span_stall (span_stall),
        .stat       (stat),
        .span_valid (span_valid),
        .span       (span)
    );

    // An empty result is always the final one and carries zero columns
    assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid && span.is_empty) |->
            (span.is_last && span.left_col == '0 && span.right_col == '0))
    else $error("empty result not final or not zeroed");

    // Spans are ordered left to right
    assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid && !span.is_empty) |-> (span.left_col <= span.right_col))
    else $error("span with left column past right column");

    // Once a triangle is taken the block is busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (triangle_valid && !triangle_stall) |=> triangle_stall)
    else $error("second triangle accepted back to back");

endmodule

`default_nettype wire
